[hdl/joint_drive_with_watchdog_hold_macros.svh]
// Assertion macros used by the joint drive RTL.
// Expects clk and rst_n in the scope of the including module.
`ifndef JOINT_DRIVE_WITH_WATCHDOG_HOLD_MACROS_SVH
`define JOINT_DRIVE_WITH_WATCHDOG_HOLD_MACROS_SVH

// same-cycle implication
`define JDWH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JDWH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/jdwh_pkg.sv]
// Shared types, codes and widths for the joint drive block.
// No dependencies; every other file but the macro header uses this package.
`timescale 1ns / 1ps
`default_nettype none

package jdwh_pkg;

    localparam int NUM_JOINTS = 16;
    localparam int JW         = 4;    // joint index width
    localparam int DW         = 32;   // Q16.16 data width
    localparam int GW         = 16;   // Q8.8 gain width
    localparam int CNTW       = 20;   // watchdog counter width
    localparam int MW         = 33;   // multiplier operand width
    localparam int PW         = 64;   // kept product width
    localparam int AW         = 52;   // PD accumulator width
    localparam int CFG_IW     = 3;    // register index width

    localparam logic [JW:0] JOINTS_MAX = (JW + 1)'(NUM_JOINTS);

    // request kinds
    localparam logic [1:0] REQ_TOPIC  = 2'd0;
    localparam logic [1:0] REQ_SLIDER = 2'd1;
    localparam logic [1:0] REQ_STEP   = 2'd2;

    // control modes
    localparam logic [1:0] MODE_POS = 2'd0;
    localparam logic [1:0] MODE_VEL = 2'd1;
    localparam logic [1:0] MODE_TRQ = 2'd2;

    // actuator kinds
    localparam logic [1:0] ACT_MOTOR     = 2'd0;
    localparam logic [1:0] ACT_POS_SERVO = 2'd1;
    localparam logic [1:0] ACT_VEL_SERVO = 2'd2;

    // register indexes
    localparam logic [CFG_IW-1:0] CFG_CONTROL_MODE   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_HOLD_GAIN_P    = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_HOLD_GAIN_D    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_TIMEOUT_TICKS  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_STEP_TIME      = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_ACTUATOR_TYPES = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_NUM_JOINTS     = 3'd6;

    typedef logic [JW-1:0]        joint_t;
    typedef logic signed [DW-1:0] fix_t;

    typedef struct packed {
        logic [1:0]      control_mode;
        logic [GW-1:0]   hold_gain_p;
        logic [GW-1:0]   hold_gain_d;
        logic [CNTW-1:0] timeout_ticks;
        logic [DW-1:0]   step_time;
        logic [DW-1:0]   actuator_types;
        logic [JW:0]     num_joints;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_VMUL,
        S_VADD,
        S_PMUL,
        S_DMUL,
        S_DSUB,
        S_SAT,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_MUL,
        MAC_LOAD_MUL,
        MAC_SUB
    } mac_op_t;

    typedef struct packed {
        mac_op_t              op;
        logic signed [MW-1:0] a;
        logic signed [MW-1:0] b;
        logic signed [AW-1:0] addend;
    } mac_cmd_t;

    typedef struct packed {
        logic signed [PW-1:0] prod;
        logic signed [AW-1:0] acc;
    } mac_res_t;

endpackage

`default_nettype wire

[hdl/jdwh_req_if.sv]
// Request channel: valid/ready handshake plus one input item.
// Depends on jdwh_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface jdwh_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic [jdwh_pkg::JW-1:0]       joint_index;
    logic signed [jdwh_pkg::DW-1:0] command_value;
    logic                          dragging;
    logic signed [jdwh_pkg::DW-1:0] measured_position;
    logic signed [jdwh_pkg::DW-1:0] measured_velocity;
    logic signed [jdwh_pkg::DW-1:0] bias_force;

    modport source (
        output valid, req_type, joint_index, command_value, dragging,
               measured_position, measured_velocity, bias_force,
        input  ready
    );
    modport sink (
        input  valid, req_type, joint_index, command_value, dragging,
               measured_position, measured_velocity, bias_force,
        output ready
    );
endinterface

`default_nettype wire

[hdl/jdwh_drv_if.sv]
// Drive result channel: valid/ready handshake plus one result item.
// Depends on jdwh_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface jdwh_drv_if;
    logic                           valid;
    logic                           ready;
    logic [jdwh_pkg::JW-1:0]        drive_joint;
    logic signed [jdwh_pkg::DW-1:0] drive_value;
    logic                           holding;

    modport source (
        output valid, drive_joint, drive_value, holding,
        input  ready
    );
    modport sink (
        input  valid, drive_joint, drive_value, holding,
        output ready
    );
endinterface

`default_nettype wire

[hdl/joint_drive_with_watchdog_hold.sv]
// A control step runs from acceptance through the sequencer states to its drive beat;
// the PD path with velocity integration is the longest, set by the sequencer
// running the one shared 33x33 multiplier through up to three passes.
// Requests are taken only in S_IDLE, so a new step waits until the last is loaded out.
// Reset: targets, watchdog and hold clear at once, registers return to defaults.
// Top level of the joint drive block: config file, shared MAC unit and sequencer.
`timescale 1ns / 1ps
`default_nettype none

module joint_drive_with_watchdog_hold (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    jdwh_req_if.sink                         req,
    jdwh_drv_if.source                       drv,
    input  wire logic                        cfg_we,
    input  wire logic [jdwh_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [jdwh_pkg::DW-1:0]     cfg_data
);
    import jdwh_pkg::*;

    cfg_t     cfg;
    mac_cmd_t mac_cmd;
    mac_res_t mac_res;

    jdwh_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    jdwh_mac u_mac (
        .clk (clk),
        .cmd (mac_cmd),
        .res (mac_res)
    );

    jdwh_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .mac_cmd (mac_cmd),
        .mac_res (mac_res),
        .req     (req),
        .drv     (drv)
    );

endmodule

`default_nettype wire

[hdl/jdwh_cfg.sv]
// Configuration register file written through a plain write port.
// Depends on jdwh_pkg for cfg_t and the register indexes.
`timescale 1ns / 1ps
`default_nettype none

module jdwh_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        we,
    input  wire logic [jdwh_pkg::CFG_IW-1:0] index,
    input  wire logic [jdwh_pkg::DW-1:0]     data,
    output jdwh_pkg::cfg_t                   cfg
);
    import jdwh_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            unique case (index)
                CFG_CONTROL_MODE:   cfg_next.control_mode   = data[1:0];
                CFG_HOLD_GAIN_P:    cfg_next.hold_gain_p    = data[GW-1:0];
                CFG_HOLD_GAIN_D:    cfg_next.hold_gain_d    = data[GW-1:0];
                CFG_TIMEOUT_TICKS:  cfg_next.timeout_ticks  = data[CNTW-1:0];
                CFG_STEP_TIME:      cfg_next.step_time      = data;
                CFG_ACTUATOR_TYPES: cfg_next.actuator_types = data;
                CFG_NUM_JOINTS:     cfg_next.num_joints     = data[JW:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.control_mode   <= MODE_TRQ;
            cfg_reg.hold_gain_p    <= GW'(1280);
            cfg_reg.hold_gain_d    <= GW'(256);
            cfg_reg.timeout_ticks  <= CNTW'(500);
            cfg_reg.step_time      <= DW'(4294967);
            cfg_reg.actuator_types <= '0;
            cfg_reg.num_joints     <= JOINTS_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[hdl/jdwh_mac.sv]
// Shared 33x33 signed multiplier with a product register and a PD accumulator.
// Depends on jdwh_pkg for the command and result structs.
`timescale 1ns / 1ps
`default_nettype none

module jdwh_mac (
    input  wire logic           clk,
    input  jdwh_pkg::mac_cmd_t  cmd,
    output jdwh_pkg::mac_res_t  res
);
    import jdwh_pkg::*;

    logic signed [2*MW-1:0] product;
    logic signed [PW-1:0]   prod_reg;
    logic signed [AW-1:0]   acc_reg;

    assign product = cmd.a * cmd.b;

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            MAC_MUL:
            begin
                prod_reg <= signed'(product[PW-1:0]);
            end
            MAC_LOAD_MUL:
            begin
                // seed the accumulator from the previous product, start the next one
                acc_reg  <= signed'(prod_reg[AW-1:0]) + cmd.addend;
                prod_reg <= signed'(product[PW-1:0]);
            end
            MAC_SUB:
            begin
                acc_reg <= acc_reg - signed'(prod_reg[AW-1:0]);
            end
            MAC_HOLD:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    assign res.prod = prod_reg;
    assign res.acc  = acc_reg;

endmodule

`default_nettype wire

[hdl/jdwh_ctrl.sv]
// Sequencer, joint target storage, watchdog and output register.
// Depends on jdwh_pkg, the two channel interfaces and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "joint_drive_with_watchdog_hold_macros.svh"

module jdwh_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  jdwh_pkg::cfg_t     cfg,
    output jdwh_pkg::mac_cmd_t mac_cmd,
    input  jdwh_pkg::mac_res_t mac_res,
    jdwh_req_if.sink           req,
    jdwh_drv_if.source         drv
);
    import jdwh_pkg::*;

    localparam logic [CNTW-1:0] CNT_MAX = '1;

    function automatic fix_t sat33(input logic signed [DW:0] x);
        if (x[DW] != x[DW-1])
            return x[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        return signed'(x[DW-1:0]);
    endfunction

    function automatic fix_t sat_acc(input logic signed [AW-9:0] x);
        if ((&x[AW-9:DW-1]) || !(|x[AW-9:DW-1]))
            return signed'(x[DW-1:0]);
        return x[AW-9] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    endfunction

    function automatic logic [1:0] act_of(input joint_t j, input logic [DW-1:0] types);
        return types[{j, 1'b0} +: 2];
    endfunction

    state_t state_reg, state_next;

    fix_t            pt_reg [NUM_JOINTS];
    fix_t            ct_reg [NUM_JOINTS];
    logic            hold_reg;
    logic            slider_reg;
    logic            capture_reg;
    logic [CNTW-1:0] cnt_reg;

    joint_t j_reg;
    fix_t   pos_reg, vel_reg, bias_reg;
    fix_t   drive_reg;

    logic   out_valid_reg;
    joint_t out_joint_reg;
    fix_t   out_value_reg;
    logic   out_hold_reg;

    logic [JW:0]     jcnt;
    logic            in_ok, in_last, accept;
    logic            acc_topic, acc_slider, acc_step;
    logic [CNTW-1:0] cnt_inc;
    logic            trip, cap_eff;

    logic [1:0]           act_cur;
    logic                 direct;
    fix_t                 tgt, cmdt, drive_dec;
    logic signed [DW:0]   diff, sum_v, sum_t;
    logic signed [AW-9:0] acc_sh;

    logic   pt_we, ct_we;
    joint_t pt_addr;
    fix_t   pt_wdata;
    logic   out_free, out_load;

    // ---------------- input decode and watchdog ----------------
    always_comb
    begin
        if (cfg.num_joints == '0)
            jcnt = (JW + 1)'(1);
        else if (cfg.num_joints > JOINTS_MAX)
            jcnt = JOINTS_MAX;
        else
            jcnt = cfg.num_joints;
    end

    assign in_ok      = {1'b0, req.joint_index} < jcnt;
    assign in_last    = {1'b0, req.joint_index} == (jcnt - (JW + 1)'(1));
    assign accept     = req.valid && req.ready;
    assign acc_topic  = accept && in_ok && (req.req_type == REQ_TOPIC);
    assign acc_slider = accept && in_ok && (req.req_type == REQ_SLIDER);
    assign acc_step   = accept && in_ok && (req.req_type == REQ_STEP);

    // watchdog advances on the step of joint 0 only
    assign cnt_inc = ((req.joint_index == '0) && (cnt_reg != CNT_MAX))
                   ? cnt_reg + CNTW'(1) : cnt_reg;
    assign trip    = (req.joint_index == '0) && (cnt_inc > cfg.timeout_ticks)
                   && !hold_reg && !slider_reg;
    assign cap_eff = capture_reg || trip;

    // ---------------- datapath around the shared unit ----------------
    assign act_cur = act_of(j_reg, cfg.actuator_types);
    assign direct  = (act_cur == ACT_POS_SERVO);
    assign tgt     = pt_reg[j_reg];
    assign cmdt    = ct_reg[j_reg];
    assign diff    = {tgt[DW-1], tgt} - {pos_reg[DW-1], pos_reg};
    assign sum_v   = {tgt[DW-1], tgt} + {mac_res.prod[PW-1], mac_res.prod[PW-1:DW]};
    assign sum_t   = {cmdt[DW-1], cmdt} + {bias_reg[DW-1], bias_reg};
    assign acc_sh  = signed'(mac_res.acc[AW-1:8]);

    // drive picked at decode; overwritten later when the velocity or PD path runs
    always_comb
    begin
        unique case (cfg.control_mode)
            MODE_POS: drive_dec = tgt;
            MODE_VEL:
            begin
                if (act_cur == ACT_VEL_SERVO)
                    drive_dec = hold_reg ? '0 : cmdt;
                else
                    drive_dec = tgt;
            end
            MODE_TRQ: drive_dec = hold_reg ? tgt : sat33(sum_t);
            default:  drive_dec = '0;
        endcase
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc_step)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                unique case (cfg.control_mode)
                    MODE_POS: state_next = direct ? S_DONE : S_PMUL;
                    MODE_VEL:
                    begin
                        if (act_cur == ACT_VEL_SERVO)
                            state_next = S_DONE;
                        else if (!hold_reg)
                            state_next = S_VMUL;
                        else
                            state_next = direct ? S_DONE : S_PMUL;
                    end
                    MODE_TRQ:
                    begin
                        if (!hold_reg)
                            state_next = S_DONE;
                        else
                            state_next = direct ? S_DONE : S_PMUL;
                    end
                    default:  state_next = S_DONE;
                endcase
            end
            S_VMUL: state_next = S_VADD;
            S_VADD: state_next = direct ? S_DONE : S_PMUL;
            S_PMUL: state_next = S_DMUL;
            S_DMUL: state_next = S_DSUB;
            S_DSUB: state_next = S_SAT;
            S_SAT:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb
    begin
        req.ready      = 1'b0;
        mac_cmd.op     = MAC_HOLD;
        mac_cmd.a      = '0;
        mac_cmd.b      = '0;
        mac_cmd.addend = '0;
        out_load       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
            end
            S_VMUL:
            begin
                mac_cmd.op = MAC_MUL;
                mac_cmd.a  = {cmdt[DW-1], cmdt};
                mac_cmd.b  = {1'b0, cfg.step_time};
            end
            S_PMUL:
            begin
                mac_cmd.op = MAC_MUL;
                mac_cmd.a  = {{(MW - GW){1'b0}}, cfg.hold_gain_p};
                mac_cmd.b  = diff;
            end
            S_DMUL:
            begin
                // acc = kp*err + bias*256, then kd*vel goes into the product
                mac_cmd.op     = MAC_LOAD_MUL;
                mac_cmd.a      = {{(MW - GW){1'b0}}, cfg.hold_gain_d};
                mac_cmd.b      = {vel_reg[DW-1], vel_reg};
                mac_cmd.addend = {{(AW - DW - 8){bias_reg[DW-1]}}, bias_reg, 8'b0};
            end
            S_DSUB:
            begin
                mac_cmd.op = MAC_SUB;
            end
            S_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // ---------------- target write port ----------------
    always_comb
    begin
        pt_we    = 1'b0;
        pt_addr  = req.joint_index;
        pt_wdata = req.command_value;
        if (state_reg == S_VADD)
        begin
            pt_we    = 1'b1;
            pt_addr  = j_reg;
            pt_wdata = sat33(sum_v);
        end
        else if (acc_topic)
        begin
            pt_we = !slider_reg && (cfg.control_mode == MODE_POS);
        end
        else if (acc_slider)
        begin
            pt_we = 1'b1;
        end
        else if (acc_step)
        begin
            // capture the measured position as the hold target
            pt_we    = cap_eff;
            pt_wdata = req.measured_position;
        end
    end

    assign ct_we    = acc_topic && !slider_reg;
    assign out_free = !out_valid_reg || drv.ready;

    // ---------------- control state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hold_reg      <= 1'b0;
            slider_reg    <= 1'b0;
            capture_reg   <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_JOINTS; i++)
            begin
                pt_reg[i] <= '0;
                ct_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (pt_we)
                pt_reg[pt_addr] <= pt_wdata;
            if (ct_we)
                ct_reg[req.joint_index] <= req.command_value;
            if (acc_topic && !slider_reg && in_last)
            begin
                cnt_reg  <= '0;
                hold_reg <= 1'b0;
            end
            if (acc_slider)
            begin
                slider_reg <= req.dragging;
                hold_reg   <= 1'b1;
            end
            if (acc_step)
            begin
                cnt_reg     <= cnt_inc;
                capture_reg <= cap_eff && !in_last;
                if (trip)
                    hold_reg <= 1'b1;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (drv.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge clk)
    begin
        if (acc_step)
        begin
            j_reg    <= req.joint_index;
            pos_reg  <= req.measured_position;
            vel_reg  <= req.measured_velocity;
            bias_reg <= req.bias_force;
        end
        unique case (state_reg)
            S_DECODE: drive_reg <= drive_dec;
            S_VADD:   drive_reg <= sat33(sum_v);
            S_SAT:    drive_reg <= sat_acc(acc_sh);
            default:  drive_reg <= drive_reg;
        endcase
        if (out_load)
        begin
            out_joint_reg <= j_reg;
            out_value_reg <= drive_reg;
            out_hold_reg  <= hold_reg || slider_reg;
        end
    end

    assign drv.valid       = out_valid_reg;
    assign drv.drive_joint = out_joint_reg;
    assign drv.drive_value = out_value_reg;
    assign drv.holding     = out_hold_reg;

    // ---------------- checks ----------------
    `JDWH_ASSERT_NEXT(a_step_enters_decode, acc_step, state_reg == S_DECODE, "step not started")
    `JDWH_ASSERT_NOW(a_capture_sets_hold, $rose(capture_reg), hold_reg, "capture without hold")
    `JDWH_ASSERT_NOW(a_target_write_slot, pt_we, (state_reg == S_IDLE) || (state_reg == S_VADD), "target write out of slot")
    `JDWH_ASSERT_NEXT(a_done_loads_out, out_load, out_valid_reg && (out_joint_reg == $past(j_reg)), "result not loaded")

endmodule

`default_nettype wire
